// ===== hdl/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;

  // Arena geometry
  localparam int PAGE_BYTES   = 4096;
  localparam int MAX_PAGES    = 8;
  localparam int HEADER_BYTES = 8;
  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int ARENA_BYTES  = PAGE_BYTES * MAX_PAGES;
  localparam int DEPTH        = (ARENA_BYTES + 3) / 4;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int OFF_W        = $clog2(ARENA_BYTES) + 1;
  localparam int SIZE_W       = 17;
  localparam int PAGE_W       = $clog2(MAX_PAGES + 1);
  localparam int ENTRY_W      = SIZE_W + 1;

  // Result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_OOM      = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  // Opcodes of an input item
  localparam logic OPC_ALLOC = 1'b0;
  localparam logic OPC_FREE  = 1'b1;

  // Datapath micro-operations
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_INIT     = 4'd1;
  localparam logic [3:0] OP_LOAD     = 4'd2;
  localparam logic [3:0] OP_RD_OFF   = 4'd3;
  localparam logic [3:0] OP_STEP     = 4'd4;
  localparam logic [3:0] OP_A_TAKE   = 4'd5;
  localparam logic [3:0] OP_A_REST   = 4'd6;
  localparam logic [3:0] OP_GROW     = 4'd7;
  localparam logic [3:0] OP_RESTART  = 4'd8;
  localparam logic [3:0] OP_M_HOLD   = 4'd9;
  localparam logic [3:0] OP_M_MERGE  = 4'd10;
  localparam logic [3:0] OP_M_ADV    = 4'd11;
  localparam logic [3:0] OP_F_MATCH  = 4'd12;
  localparam logic [3:0] OP_F_WRITE  = 4'd13;
  localparam logic [3:0] OP_FAIL_OOM = 4'd14;
  localparam logic [3:0] OP_FAIL_NF  = 4'd15;

  typedef struct packed {
    logic [3:0] op;
    logic       publish;
  } ffha_cmd_t;

  typedef struct packed {
    logic in_free;
    logic off_lt_end;
    logic fit;
    logic rd_free;
    logic rnxt_lt_end;
    logic mnxt_lt_end;
    logic addr_match;
    logic pages_full;
  } ffha_stat_t;

  // Byte offset to header store index, clamped to the last entry
  function automatic logic [IDX_W-1:0] hdr_idx(input logic [OFF_W-1:0] off);
    logic [OFF_W-3:0] w;
    w = off[OFF_W-1:2];
    if (w >= (OFF_W-2)'(DEPTH)) hdr_idx = IDX_W'(DEPTH - 1);
    else hdr_idx = w[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ffha_if.sv =====
`default_nettype none
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] request_bytes;
  logic [31:0] release_address;
  modport source (output valid, opcode, request_bytes, release_address, input ready);
  modport sink (input valid, opcode, request_bytes, release_address, output ready);
endinterface

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] block_address;
  modport source (output valid, status, block_address, input ready);
  modport sink (input valid, status, block_address, output ready);
endinterface

interface ffha_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] heap_base;
  modport source (output valid, heap_base, input ready);
  modport sink (input valid, heap_base, output ready);
endinterface
`default_nettype wire

// ===== hdl/ffha_dp.sv =====
`default_nettype none
module ffha_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ffha_pkg::ffha_cmd_t cmd,
  output ffha_pkg::ffha_stat_t     st,
  input  wire logic                in_opcode,
  input  wire logic [15:0]         in_request_bytes,
  input  wire logic [31:0]         in_release_address,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_heap_base,
  output logic [1:0]               status,
  output logic [31:0]              block_address
);

  localparam int OW = ffha_pkg::OFF_W;
  localparam int SW = ffha_pkg::SIZE_W;
  localparam logic [OW-1:0] HDR = OW'(ffha_pkg::HEADER_BYTES);

  // Header store: {free, size} per 4-byte word
  logic [ffha_pkg::ENTRY_W-1:0] mem [ffha_pkg::DEPTH];
  logic [ffha_pkg::ENTRY_W-1:0] rdata;
  logic                         we;
  logic [ffha_pkg::IDX_W-1:0]   waddr;
  logic [ffha_pkg::IDX_W-1:0]   raddr;
  logic [ffha_pkg::ENTRY_W-1:0] wdata;

  // Walk registers
  logic [OW-1:0] off;
  logic [OW-1:0] prev;
  logic [OW-1:0] cur;
  logic [SW-1:0] hsize;
  logic [SW-1:0] psize;
  logic          pfree;
  logic          has_prev;
  logic [SW-1:0] need;
  logic [31:0]   rel_addr;
  logic [31:0]   heap_base;
  logic [ffha_pkg::PAGE_W-1:0] pages;
  logic [1:0]    res_status;
  logic [31:0]   res_addr;

  // Derived values
  logic [OW-1:0] end_off;
  logic [SW-1:0] rd_size;
  logic          rd_free;
  logic [OW-1:0] rnxt;
  logic [SW-1:0] msize;
  logic [OW-1:0] mnxt;
  logic          psel;
  logic [OW-1:0] f_cur;
  logic [SW-1:0] f_size;
  logic [OW-1:0] fnxt;
  logic [OW-1:0] hnxt;
  logic          fmerge;
  logic [SW-1:0] fsize_w;
  logic [31:0]   pay_addr;

  assign end_off  = (OW'(pages) << ffha_pkg::PAGE_SHIFT) - HDR;
  assign rd_size  = rdata[SW-1:0];
  assign rd_free  = rdata[SW];
  assign rnxt     = off + HDR + OW'(rd_size);
  assign msize    = hsize + SW'(ffha_pkg::HEADER_BYTES) + rd_size;
  assign mnxt     = off + HDR + OW'(msize);
  assign psel     = has_prev & pfree;
  assign f_cur    = psel ? prev : off;
  assign f_size   = psel ? (psize + SW'(ffha_pkg::HEADER_BYTES) + rd_size) : rd_size;
  assign fnxt     = f_cur + HDR + OW'(f_size);
  assign hnxt     = cur + HDR + OW'(hsize);
  assign fmerge   = (hnxt < end_off) & rd_free;
  assign fsize_w  = fmerge ? msize : hsize;
  assign pay_addr = heap_base + 32'(off) + 32'(ffha_pkg::HEADER_BYTES);

  // Status flags to the controller
  always_comb begin
    st.in_free     = in_opcode;
    st.off_lt_end  = off < end_off;
    st.fit         = rd_free &
                     (({1'b0, need} + (SW+1)'(ffha_pkg::HEADER_BYTES)) < {1'b0, rd_size});
    st.rd_free     = rd_free;
    st.rnxt_lt_end = rnxt < end_off;
    st.mnxt_lt_end = mnxt < end_off;
    st.addr_match  = pay_addr == rel_addr;
    st.pages_full  = pages >= ffha_pkg::PAGE_W'(ffha_pkg::MAX_PAGES);
  end

  // Store port selection
  always_comb begin
    we    = 1'b0;
    waddr = ffha_pkg::hdr_idx(off);
    wdata = {1'b1, hsize};
    raddr = ffha_pkg::hdr_idx(off);
    case (cmd.op)
      ffha_pkg::OP_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {1'b1, SW'(ffha_pkg::PAGE_BYTES - 2 * ffha_pkg::HEADER_BYTES)};
      end
      ffha_pkg::OP_A_TAKE: begin
        we    = 1'b1;
        wdata = {1'b0, need};
      end
      ffha_pkg::OP_A_REST: begin
        we    = 1'b1;
        waddr = ffha_pkg::hdr_idx(off + HDR + OW'(need));
        wdata = {1'b1, hsize - need - SW'(ffha_pkg::HEADER_BYTES)};
      end
      ffha_pkg::OP_GROW: begin
        we    = 1'b1;
        waddr = ffha_pkg::hdr_idx(end_off);
        wdata = {1'b1, SW'(ffha_pkg::PAGE_BYTES - ffha_pkg::HEADER_BYTES)};
      end
      ffha_pkg::OP_M_HOLD: raddr = ffha_pkg::hdr_idx(rnxt);
      ffha_pkg::OP_M_MERGE: begin
        we    = 1'b1;
        wdata = {1'b1, msize};
        raddr = ffha_pkg::hdr_idx(mnxt);
      end
      ffha_pkg::OP_F_MATCH: raddr = ffha_pkg::hdr_idx(fnxt);
      ffha_pkg::OP_F_WRITE: begin
        we    = 1'b1;
        waddr = ffha_pkg::hdr_idx(cur);
        wdata = {1'b1, fsize_w};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // Walk registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      ffha_pkg::OP_LOAD: begin
        off        <= '0;
        has_prev   <= 1'b0;
        need       <= ({1'b0, in_request_bytes} + SW'(3)) & ~SW'(3);
        rel_addr   <= in_release_address;
        res_status <= ffha_pkg::ST_DONE;
        res_addr   <= '0;
      end
      ffha_pkg::OP_STEP: begin
        prev     <= off;
        psize    <= rd_size;
        pfree    <= rd_free;
        has_prev <= 1'b1;
        off      <= rnxt;
      end
      ffha_pkg::OP_A_TAKE: begin
        hsize    <= rd_size;
        res_addr <= pay_addr;
      end
      ffha_pkg::OP_GROW, ffha_pkg::OP_RESTART: off <= '0;
      ffha_pkg::OP_M_HOLD: hsize <= rd_size;
      ffha_pkg::OP_M_MERGE: hsize <= msize;
      ffha_pkg::OP_M_ADV: off <= off + HDR + OW'(hsize);
      ffha_pkg::OP_F_MATCH: begin
        cur   <= f_cur;
        hsize <= f_size;
      end
      ffha_pkg::OP_FAIL_OOM: begin
        res_status <= ffha_pkg::ST_OOM;
        res_addr   <= '0;
      end
      ffha_pkg::OP_FAIL_NF: begin
        res_status <= ffha_pkg::ST_NOTFOUND;
        res_addr   <= '0;
      end
      default: ;
    endcase
    if (cmd.publish) begin
      status        <= res_status;
      block_address <= res_addr;
    end
  end

  // Page count and base register
  always_ff @(posedge clk) begin
    if (rst) begin
      pages     <= ffha_pkg::PAGE_W'(1);
      heap_base <= '0;
    end else begin
      if (cmd.op == ffha_pkg::OP_GROW) pages <= pages + ffha_pkg::PAGE_W'(1);
      if (cfg_we) heap_base <= cfg_heap_base;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ffha_ctrl.sv =====
`default_nettype none
module ffha_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire ffha_pkg::ffha_stat_t st,
  output ffha_pkg::ffha_cmd_t       cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_A_RD   = 4'd2;
  localparam logic [3:0] S_A_CHK  = 4'd3;
  localparam logic [3:0] S_A_REST = 4'd4;
  localparam logic [3:0] S_GROW   = 4'd5;
  localparam logic [3:0] S_M_RD   = 4'd6;
  localparam logic [3:0] S_M_CHK  = 4'd7;
  localparam logic [3:0] S_M_NX   = 4'd8;
  localparam logic [3:0] S_M_ADV  = 4'd9;
  localparam logic [3:0] S_F_RD   = 4'd10;
  localparam logic [3:0] S_F_CHK  = 4'd11;
  localparam logic [3:0] S_F_NX   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       can_pub;

  assign in_ready = state == S_IDLE;
  assign can_pub  = !out_valid || out_ready;

  // Next state and command
  always_comb begin
    state_next  = state;
    cmd.op      = ffha_pkg::OP_NONE;
    cmd.publish = 1'b0;
    case (state)
      S_INIT: begin
        cmd.op     = ffha_pkg::OP_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = ffha_pkg::OP_LOAD;
          state_next = (st.in_free == ffha_pkg::OPC_FREE) ? S_F_RD : S_A_RD;
        end
      end
      S_A_RD: begin
        if (st.off_lt_end) begin
          cmd.op     = ffha_pkg::OP_RD_OFF;
          state_next = S_A_CHK;
        end else begin
          state_next = S_GROW;
        end
      end
      S_A_CHK: begin
        if (st.fit) begin
          cmd.op     = ffha_pkg::OP_A_TAKE;
          state_next = S_A_REST;
        end else begin
          cmd.op     = ffha_pkg::OP_STEP;
          state_next = S_A_RD;
        end
      end
      S_A_REST: begin
        cmd.op     = ffha_pkg::OP_A_REST;
        state_next = S_DONE;
      end
      S_GROW: begin
        if (st.pages_full) begin
          cmd.op     = ffha_pkg::OP_FAIL_OOM;
          state_next = S_DONE;
        end else begin
          cmd.op     = ffha_pkg::OP_GROW;
          state_next = S_M_RD;
        end
      end
      S_M_RD: begin
        if (st.off_lt_end) begin
          cmd.op     = ffha_pkg::OP_RD_OFF;
          state_next = S_M_CHK;
        end else begin
          cmd.op     = ffha_pkg::OP_RESTART;
          state_next = S_A_RD;
        end
      end
      S_M_CHK: begin
        if (st.rd_free && st.rnxt_lt_end) begin
          cmd.op     = ffha_pkg::OP_M_HOLD;
          state_next = S_M_NX;
        end else begin
          cmd.op     = ffha_pkg::OP_STEP;
          state_next = S_M_RD;
        end
      end
      S_M_NX: begin
        if (st.rd_free) begin
          cmd.op     = ffha_pkg::OP_M_MERGE;
          state_next = st.mnxt_lt_end ? S_M_NX : S_M_ADV;
        end else begin
          cmd.op     = ffha_pkg::OP_M_ADV;
          state_next = S_M_RD;
        end
      end
      S_M_ADV: begin
        cmd.op     = ffha_pkg::OP_M_ADV;
        state_next = S_M_RD;
      end
      S_F_RD: begin
        if (st.off_lt_end) begin
          cmd.op     = ffha_pkg::OP_RD_OFF;
          state_next = S_F_CHK;
        end else begin
          cmd.op     = ffha_pkg::OP_FAIL_NF;
          state_next = S_DONE;
        end
      end
      S_F_CHK: begin
        if (st.addr_match) begin
          cmd.op     = ffha_pkg::OP_F_MATCH;
          state_next = S_F_NX;
        end else begin
          cmd.op     = ffha_pkg::OP_STEP;
          state_next = S_F_RD;
        end
      end
      S_F_NX: begin
        cmd.op     = ffha_pkg::OP_F_WRITE;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (can_pub) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/first_fit_heap_allocator.sv =====
`default_nettype none
// First-fit heap allocator over a paged arena of block headers.
// Channels: req (sink) carries opcode, request_bytes and release_address;
// rsp (source) carries status and block_address, one result per item;
// cfg (sink) writes heap_base, always ready; the user must write it only
// while the block is idle, as the block has no check for it. Both req and
// rsp use valid/ready; an item moves when both are high. An allocate
// walks the blocks for the first that fits; each page grow adds a merge
// walk and a new search. A free walks the blocks up to the match.
// One item is in work at a time; the header walk through the single-read
// header store sets the pace; the next waits until the last is published.
// Reset: after rst falls the first page is laid out in S_INIT, then
// req.ready rises. heap_base resets to zero, one page in use.
// A stalled receiver holds rsp steady; the next item is taken and worked
// while the result waits, but its result is held until rsp is free.
module first_fit_heap_allocator (
  input  wire logic clk,
  input  wire logic rst,
  ffha_req_if.sink  req,
  ffha_rsp_if.source rsp,
  ffha_cfg_if.sink  cfg
);

  ffha_pkg::ffha_cmd_t  cmd;
  ffha_pkg::ffha_stat_t st;

  assign cfg.ready = 1'b1;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  ffha_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .st                 (st),
    .in_opcode          (req.opcode),
    .in_request_bytes   (req.request_bytes),
    .in_release_address (req.release_address),
    .cfg_we             (cfg.valid),
    .cfg_heap_base      (cfg.heap_base),
    .status             (rsp.status),
    .block_address      (rsp.block_address)
  );

endmodule
`default_nettype wire
